### rtl/polar_power_difference_stats_unit_assert.svh
// Assertion macros for the polar power-difference statistics unit.
// Included by the checker module; needs nothing else.
`ifndef POLAR_POWER_DIFFERENCE_STATS_UNIT_ASSERT_SVH
`define POLAR_POWER_DIFFERENCE_STATS_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPDS_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PPDS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

### rtl/ppds_pkg.sv
// Shared types, widths and constants of the power-difference statistics unit.
// Used by the channel interfaces, the divider, the top level and the checker.
package ppds_pkg;

   localparam int POWER_BITS = 16;
   localparam int COUNT_BITS = 20;
   localparam int NUM_PAIRS  = 6;
   localparam int PAIR_W     = 3;
   localparam int THR_W      = 17;
   localparam int DIFF_W     = POWER_BITS + 1;
   localparam int CNT_W      = COUNT_BITS + 1;
   localparam int SUM_W      = DIFF_W + COUNT_BITS + 1;
   localparam int MAG_W      = SUM_W - 1;
   localparam int QUOT_W     = DIFF_W - 1;
   localparam int PROD_W     = THR_W + CNT_W + 1;
   localparam int STEP_W     = $clog2(QUOT_W);

   localparam logic [PAIR_W-1:0] PAIR_HC_HX = 3'd0;
   localparam logic [PAIR_W-1:0] PAIR_HC_VC = 3'd1;
   localparam logic [PAIR_W-1:0] PAIR_HC_VX = 3'd2;
   localparam logic [PAIR_W-1:0] PAIR_VC_HX = 3'd3;
   localparam logic [PAIR_W-1:0] PAIR_VC_VX = 3'd4;
   localparam logic [PAIR_W-1:0] PAIR_HX_VX = 3'd5;
   localparam logic [PAIR_W-1:0] LAST_PAIR  = PAIR_W'(NUM_PAIRS - 1);
   localparam logic [PAIR_W-1:0] PAIR_DONE  = PAIR_W'(NUM_PAIRS);

   localparam logic [CNT_W-1:0] COUNT_LIMIT = {1'b1, {COUNT_BITS{1'b0}}};

   localparam logic signed [DIFF_W-1:0] MIN_RESET  = {1'b0, {(DIFF_W-1){1'b1}}};
   localparam logic signed [DIFF_W-1:0] MAX_RESET  = {1'b1, {(DIFF_W-1){1'b0}}};
   localparam logic signed [DIFF_W-1:0] MEAN_EMPTY = {1'b1, {(DIFF_W-1){1'b0}}};

   typedef enum logic [1:0] {
      MODE_HORIZ   = 2'd0,
      MODE_VERT    = 2'd1,
      MODE_BOTH    = 2'd2,
      MODE_UNKNOWN = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACC,
      ST_MODE_MUL,
      ST_MODE_CMP,
      ST_READ,
      ST_LOAD,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic signed [SUM_W-1:0]  sum;
      logic signed [DIFF_W-1:0] min;
      logic signed [DIFF_W-1:0] max;
   } entry_type;

   localparam entry_type ENTRY_RESET = '{sum: '0, min: MIN_RESET, max: MAX_RESET};

   // Difference of one channel pair, widened by one bit so it never wraps.
   function automatic logic signed [DIFF_W-1:0] pair_diff(
      input logic [PAIR_W-1:0]            pair,
      input logic signed [POWER_BITS-1:0] hc,
      input logic signed [POWER_BITS-1:0] hx,
      input logic signed [POWER_BITS-1:0] vc,
      input logic signed [POWER_BITS-1:0] vx
   );
      logic signed [DIFF_W-1:0] a;
      logic signed [DIFF_W-1:0] b;
      unique case (pair)
         PAIR_HC_HX: begin a = DIFF_W'(hc); b = DIFF_W'(hx); end
         PAIR_HC_VC: begin a = DIFF_W'(hc); b = DIFF_W'(vc); end
         PAIR_HC_VX: begin a = DIFF_W'(hc); b = DIFF_W'(vx); end
         PAIR_VC_HX: begin a = DIFF_W'(vc); b = DIFF_W'(hx); end
         PAIR_VC_VX: begin a = DIFF_W'(vc); b = DIFF_W'(vx); end
         default: begin a = DIFF_W'(hx); b = DIFF_W'(vx); end
      endcase
      return a - b;
   endfunction

endpackage

### rtl/ppds_req_if.sv
// Gate input channel of the power-difference statistics unit.
// Depends on ppds_pkg for the power width.
interface ppds_req_if;
   logic                                     valid;
   logic                                     ready;
   logic                                     gate_valid;
   logic signed [ppds_pkg::POWER_BITS-1:0]   power_h_co;
   logic signed [ppds_pkg::POWER_BITS-1:0]   power_h_cross;
   logic signed [ppds_pkg::POWER_BITS-1:0]   power_v_co;
   logic signed [ppds_pkg::POWER_BITS-1:0]   power_v_cross;
   logic                                     end_of_scan;

   modport source (
      output valid, gate_valid, power_h_co, power_h_cross, power_v_co, power_v_cross,
             end_of_scan,
      input  ready
   );
   modport sink (
      input  valid, gate_valid, power_h_co, power_h_cross, power_v_co, power_v_cross,
             end_of_scan,
      output ready
   );
endinterface

### rtl/ppds_rsp_if.sv
// Result channel of the power-difference statistics unit.
// Depends on ppds_pkg for field widths.
interface ppds_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [ppds_pkg::PAIR_W-1:0]          pair_index;
   logic signed [ppds_pkg::DIFF_W-1:0]   mean_difference;
   logic signed [ppds_pkg::DIFF_W-1:0]   min_difference;
   logic signed [ppds_pkg::DIFF_W-1:0]   max_difference;
   logic [ppds_pkg::CNT_W-1:0]           sample_count;
   logic [1:0]                           xmit_mode;
   logic                                 scan_empty;
   logic                                 count_overflowed;
   logic                                 last_of_run;

   modport source (
      output valid, pair_index, mean_difference, min_difference, max_difference,
             sample_count, xmit_mode, scan_empty, count_overflowed, last_of_run,
      input  ready
   );
   modport sink (
      input  valid, pair_index, mean_difference, min_difference, max_difference,
             sample_count, xmit_mode, scan_empty, count_overflowed, last_of_run,
      output ready
   );
endinterface

### rtl/ppds_divider.sv
// Unsigned restoring divider, one quotient bit per cycle, for the scan means.
// Depends on ppds_pkg for operand widths.
module ppds_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [ppds_pkg::MAG_W-1:0]     dividend,
   input  logic [ppds_pkg::CNT_W-1:0]     divisor,
   output logic                           done,
   output logic [ppds_pkg::QUOT_W-1:0]    quotient
);

   logic                              busy_ff, busy_in;
   logic [ppds_pkg::STEP_W-1:0]       step_ff, step_in;
   logic [ppds_pkg::CNT_W-1:0]        rem_ff, rem_in;
   logic [ppds_pkg::QUOT_W-1:0]       quot_ff, quot_in;
   logic [ppds_pkg::CNT_W:0]          shifted;
   logic [ppds_pkg::CNT_W:0]          trial;
   logic                              fits;

   // The quotient is known to fit in QUOT_W bits, so the upper dividend bits
   // start out below the divisor and the remainder never needs more than CNT_W bits.
   always_comb begin
      shifted = {rem_ff, quot_ff[ppds_pkg::QUOT_W-1]};
      trial   = shifted - {1'b0, divisor};
      fits    = (shifted >= {1'b0, divisor});
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = ppds_pkg::STEP_W'(ppds_pkg::QUOT_W - 1);
         rem_in  = ppds_pkg::CNT_W'(dividend >> ppds_pkg::QUOT_W);
         quot_in = dividend[ppds_pkg::QUOT_W-1:0];
      end else if (busy_ff) begin
         rem_in  = fits ? trial[ppds_pkg::CNT_W-1:0] : shifted[ppds_pkg::CNT_W-1:0];
         quot_in = {quot_ff[ppds_pkg::QUOT_W-2:0], fits};
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign done     = busy_ff && (step_ff == '0);
   assign quotient = quot_ff;

endmodule

### rtl/polar_power_difference_stats_unit.sv
// Top level of the polar power-difference statistics unit.
// Depends on ppds_pkg, ppds_req_if, ppds_rsp_if and ppds_divider.
//
//   channel  direction  handshake           carries
//   req_ch   in         valid/ready         one range gate
//   rsp_ch   out        valid/ready         one per-pair result, six per scan
//   csr_     in         write enable only   mode threshold
//
// A gate that is accumulated takes the transfer, then six read-modify-write passes over
// the one statistics memory, pipelined one pair per cycle plus a drain. A gate that is
// not accumulated is only transferred. End of scan adds the mode decision (multiply,
// then compare), then per pair a memory read and load, the bit-serial divider and a
// load of the output register; the divider is skipped when the scan is empty.
// Reset clears control state; per-entry valid bits make unwritten statistics read as
// their reset values, so there is no clearing pass. A stalled result holds the block.
module polar_power_difference_stats_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [ppds_pkg::THR_W-1:0]      csr_write_data,
   ppds_req_if.sink                        req_ch,
   ppds_rsp_if.source                      rsp_ch
);

   ppds_pkg::state_type                    state_ff, state_in;
   logic [ppds_pkg::PAIR_W-1:0]            pair_ff, pair_in;
   logic [ppds_pkg::CNT_W-1:0]             count_ff, count_in;
   logic                                   ovf_ff, ovf_in;
   logic signed [ppds_pkg::THR_W-1:0]      thr_ff;
   logic [ppds_pkg::NUM_PAIRS-1:0]         valid_bits_ff;
   ppds_pkg::mode_type                     mode_ff;

   logic signed [ppds_pkg::POWER_BITS-1:0] hc_ff, hx_ff, vc_ff, vx_ff;
   logic                                   eos_ff;

   ppds_pkg::entry_type                    mem [ppds_pkg::NUM_PAIRS];
   ppds_pkg::entry_type                    rd_data_ff;
   logic                                   rd_valid_ff;
   ppds_pkg::entry_type                    cur_entry;
   ppds_pkg::entry_type                    wr_data;

   logic signed [ppds_pkg::PROD_W-1:0]     prod_ff, prod_in;
   logic signed [ppds_pkg::PROD_W-1:0]     sum_x;
   logic signed [ppds_pkg::CNT_W:0]        count_s;
   logic signed [ppds_pkg::DIFF_W-1:0]     min_ff, max_ff;
   logic                                   neg_ff;
   logic [ppds_pkg::SUM_W-1:0]             mag_full;
   logic signed [ppds_pkg::DIFF_W-1:0]     diff;
   logic signed [ppds_pkg::DIFF_W-1:0]     quot_x;
   logic signed [ppds_pkg::DIFF_W-1:0]     mean;

   logic                                   req_ready;
   logic                                   accept;
   logic                                   take_gate;
   logic                                   rd_en;
   logic [ppds_pkg::PAIR_W-1:0]            rd_addr;
   logic                                   wr_en;
   logic [ppds_pkg::PAIR_W-1:0]            wr_addr;
   logic                                   div_start;
   logic                                   div_done;
   logic [ppds_pkg::QUOT_W-1:0]            div_quot;
   logic                                   out_free;
   logic                                   out_load;
   logic                                   scan_done;
   logic                                   empty;

   logic                                   rsp_valid_ff;
   logic [ppds_pkg::PAIR_W-1:0]            rsp_pair_ff;
   logic signed [ppds_pkg::DIFF_W-1:0]     rsp_mean_ff, rsp_min_ff, rsp_max_ff;
   logic [ppds_pkg::CNT_W-1:0]             rsp_count_ff;
   ppds_pkg::mode_type                     rsp_mode_ff;
   logic                                   rsp_empty_ff, rsp_ovf_ff, rsp_last_ff;

   assign accept    = req_ch.valid && req_ready;
   assign take_gate = req_ch.gate_valid && (count_ff != ppds_pkg::COUNT_LIMIT);
   assign empty     = (count_ff == '0);
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign wr_addr   = pair_ff - 1'b1;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ppds_pkg::ST_IDLE: begin
            if (accept) begin
               if (take_gate) begin
                  state_in = ppds_pkg::ST_ACC;
               end else if (req_ch.end_of_scan) begin
                  state_in = ppds_pkg::ST_MODE_MUL;
               end
            end
         end
         ppds_pkg::ST_ACC: begin
            if (pair_ff == ppds_pkg::PAIR_DONE) begin
               state_in = eos_ff ? ppds_pkg::ST_MODE_MUL : ppds_pkg::ST_IDLE;
            end
         end
         ppds_pkg::ST_MODE_MUL: state_in = ppds_pkg::ST_MODE_CMP;
         ppds_pkg::ST_MODE_CMP: state_in = ppds_pkg::ST_READ;
         ppds_pkg::ST_READ:     state_in = ppds_pkg::ST_LOAD;
         ppds_pkg::ST_LOAD:     state_in = empty ? ppds_pkg::ST_OUT : ppds_pkg::ST_DIV;
         ppds_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = ppds_pkg::ST_OUT;
            end
         end
         ppds_pkg::ST_OUT: begin
            if (out_free) begin
               state_in = (pair_ff == ppds_pkg::LAST_PAIR) ? ppds_pkg::ST_IDLE
                                                           : ppds_pkg::ST_READ;
            end
         end
         default: state_in = ppds_pkg::ST_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      req_ready = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = pair_ff;
      wr_en     = 1'b0;
      div_start = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         ppds_pkg::ST_IDLE: req_ready = 1'b1;
         ppds_pkg::ST_ACC: begin
            // Pair p is read while pair p-1 is written back, so the two never collide.
            rd_en = (pair_ff != ppds_pkg::PAIR_DONE);
            wr_en = (pair_ff != '0);
         end
         ppds_pkg::ST_MODE_MUL: begin
            rd_en   = 1'b1;
            rd_addr = ppds_pkg::PAIR_HC_VC;
         end
         ppds_pkg::ST_READ: rd_en = 1'b1;
         ppds_pkg::ST_LOAD: div_start = !empty;
         ppds_pkg::ST_OUT:  out_load = out_free;
         default: ;
      endcase
   end

   assign scan_done = out_load && (pair_ff == ppds_pkg::LAST_PAIR);

   // Entries never written since the last clear read as their reset values.
   assign cur_entry = rd_valid_ff ? rd_data_ff : ppds_pkg::ENTRY_RESET;

   always_comb begin
      diff        = ppds_pkg::pair_diff(wr_addr, hc_ff, hx_ff, vc_ff, vx_ff);
      wr_data.sum = cur_entry.sum + ppds_pkg::SUM_W'(diff);
      wr_data.min = (diff < cur_entry.min) ? diff : cur_entry.min;
      wr_data.max = (diff > cur_entry.max) ? diff : cur_entry.max;
   end

   always_comb begin
      count_s  = {1'b0, count_ff};
      prod_in  = thr_ff * count_s;
      sum_x    = ppds_pkg::PROD_W'(cur_entry.sum);
      mag_full = cur_entry.sum[ppds_pkg::SUM_W-1] ? -cur_entry.sum : cur_entry.sum;
      quot_x   = {1'b0, div_quot};
      mean     = empty ? ppds_pkg::MEAN_EMPTY : (neg_ff ? -quot_x : quot_x);
   end

   always_comb begin
      pair_in  = pair_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (accept) begin
         pair_in = '0;
         if (take_gate) begin
            count_in = count_ff + 1'b1;
         end else if (req_ch.gate_valid) begin
            ovf_in = 1'b1;
         end
      end
      if (state_ff == ppds_pkg::ST_ACC) begin
         pair_in = pair_ff + 1'b1;
      end
      if (state_ff == ppds_pkg::ST_MODE_CMP) begin
         pair_in = '0;
      end
      if (out_load) begin
         pair_in = pair_ff + 1'b1;
      end
      if (scan_done) begin
         count_in = '0;
         ovf_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ppds_pkg::ST_IDLE;
         pair_ff       <= '0;
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         thr_ff        <= '0;
         valid_bits_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pair_ff  <= pair_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         if (csr_write_enable) begin
            thr_ff <= csr_write_data;
         end
         if (scan_done) begin
            valid_bits_ff <= '0;
         end else if (wr_en) begin
            valid_bits_ff[wr_addr] <= 1'b1;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Statistics memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= valid_bits_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hc_ff  <= req_ch.power_h_co;
         hx_ff  <= req_ch.power_h_cross;
         vc_ff  <= req_ch.power_v_co;
         vx_ff  <= req_ch.power_v_cross;
         eos_ff <= req_ch.end_of_scan;
      end
      if (state_ff == ppds_pkg::ST_MODE_MUL) begin
         prod_ff <= prod_in;
      end
      // The mode compares the exact sum against threshold times count, no rounding.
      if (state_ff == ppds_pkg::ST_MODE_CMP) begin
         priority if (empty) begin
            mode_ff <= ppds_pkg::MODE_UNKNOWN;
         end else if (sum_x > prod_ff) begin
            mode_ff <= ppds_pkg::MODE_HORIZ;
         end else if (sum_x < prod_ff) begin
            mode_ff <= ppds_pkg::MODE_VERT;
         end else begin
            mode_ff <= ppds_pkg::MODE_BOTH;
         end
      end
      if (state_ff == ppds_pkg::ST_LOAD) begin
         min_ff <= cur_entry.min;
         max_ff <= cur_entry.max;
         neg_ff <= cur_entry.sum[ppds_pkg::SUM_W-1];
      end
      if (out_load) begin
         rsp_pair_ff  <= pair_ff;
         rsp_mean_ff  <= mean;
         rsp_min_ff   <= min_ff;
         rsp_max_ff   <= max_ff;
         rsp_count_ff <= count_ff;
         rsp_mode_ff  <= mode_ff;
         rsp_empty_ff <= empty;
         rsp_ovf_ff   <= ovf_ff;
         rsp_last_ff  <= (pair_ff == ppds_pkg::LAST_PAIR);
      end
   end

   ppds_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mag_full[ppds_pkg::MAG_W-1:0]),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign req_ch.ready            = req_ready;
   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.pair_index       = rsp_pair_ff;
   assign rsp_ch.mean_difference  = rsp_mean_ff;
   assign rsp_ch.min_difference   = rsp_min_ff;
   assign rsp_ch.max_difference   = rsp_max_ff;
   assign rsp_ch.sample_count     = rsp_count_ff;
   assign rsp_ch.xmit_mode        = rsp_mode_ff;
   assign rsp_ch.scan_empty       = rsp_empty_ff;
   assign rsp_ch.count_overflowed = rsp_ovf_ff;
   assign rsp_ch.last_of_run      = rsp_last_ff;

endmodule

### rtl/ppds_checker.sv
// Port-level checks on the results of the power-difference statistics unit,
// bound to the top level. Depends on ppds_pkg and the assertion macro header.
`include "polar_power_difference_stats_unit_assert.svh"

module ppds_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [ppds_pkg::PAIR_W-1:0]        rsp_pair_index,
   input logic signed [ppds_pkg::DIFF_W-1:0] rsp_mean,
   input logic signed [ppds_pkg::DIFF_W-1:0] rsp_min,
   input logic signed [ppds_pkg::DIFF_W-1:0] rsp_max,
   input logic [ppds_pkg::CNT_W-1:0]         rsp_sample_count,
   input logic [1:0]                         rsp_xmit_mode,
   input logic                               rsp_scan_empty,
   input logic                               rsp_last_of_run
);

   // A stalled result stays offered.
   `PPDS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // Only the sixth pair closes a scan.
   `PPDS_ASSERT_IMPL(a_last_pair, clock, reset, rsp_valid, rsp_last_of_run == (rsp_pair_index == ppds_pkg::LAST_PAIR))

   // An empty scan has no count and no mode decision.
   `PPDS_ASSERT_IMPL(a_empty_scan, clock, reset, rsp_valid && rsp_scan_empty, rsp_xmit_mode == ppds_pkg::MODE_UNKNOWN && rsp_sample_count == '0)

   // A filled scan has a count and a decided mode.
   `PPDS_ASSERT_IMPL(a_filled_scan, clock, reset, rsp_valid && !rsp_scan_empty, rsp_xmit_mode != ppds_pkg::MODE_UNKNOWN && rsp_sample_count != '0)

   // A truncated mean never leaves the range of the values it averages.
   `PPDS_ASSERT_IMPL(a_mean_range, clock, reset, rsp_valid && !rsp_scan_empty, rsp_min <= rsp_mean && rsp_mean <= rsp_max)

endmodule

bind polar_power_difference_stats_unit ppds_checker u_ppds_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_pair_index   (rsp_ch.pair_index),
   .rsp_mean         (rsp_ch.mean_difference),
   .rsp_min          (rsp_ch.min_difference),
   .rsp_max          (rsp_ch.max_difference),
   .rsp_sample_count (rsp_ch.sample_count),
   .rsp_xmit_mode    (rsp_ch.xmit_mode),
   .rsp_scan_empty   (rsp_ch.scan_empty),
   .rsp_last_of_run  (rsp_ch.last_of_run)
);
